>>> hdl/mlru_pkg.sv
package mlru_pkg;

    // sizing of the entry list
    localparam int MAX_ENTRIES = 16;
    localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int CAP_W       = 5;
    localparam int LIM_W       = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    // payload widths
    localparam int KEY_W  = 32;
    localparam int VAL_W  = 32;
    localparam int TIME_W = 32;
    localparam int CFG_W  = 32;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY        = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_PROMOTION_DELAY = 1'b1;

    localparam logic [CAP_W-1:0]  CAPACITY_RESET = CAP_W'(16);
    localparam logic [TIME_W-1:0] DELAY_RESET    = '0;

    // what a cell does at the next edge
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_SHIFT,
        CELL_LOAD,
        CELL_STAMP,
        CELL_WRVAL
    } cell_op_t;

    // contents of one list position
    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [VAL_W-1:0]  value;
        logic              seen;
        logic [TIME_W-1:0] stamp;
    } cell_data_t;

    // shared write data broadcast to all cells
    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [VAL_W-1:0]  value;
        logic [TIME_W-1:0] stamp;
    } cell_bus_t;

endpackage

>>> hdl/mlru_cell.sv
module mlru_cell (
    input  logic                      clk,
    input  mlru_pkg::cell_op_t        op,
    input  mlru_pkg::cell_bus_t       bus,
    input  mlru_pkg::cell_data_t      left_data,
    input  logic [mlru_pkg::KEY_W-1:0] search_key,
    output mlru_pkg::cell_data_t      data,
    output logic                      match
);

    mlru_pkg::cell_data_t data_reg;
    mlru_pkg::cell_data_t data_next;

    // key compare for the associative search
    assign match = (data_reg.key == search_key);
    assign data  = data_reg;

    // next contents by operation
    always_comb
    begin
        data_next = data_reg;
        case (op)
            mlru_pkg::CELL_HOLD:
            begin
                data_next = data_reg;
            end
            mlru_pkg::CELL_SHIFT:
            begin
                data_next = left_data;
            end
            mlru_pkg::CELL_LOAD:
            begin
                data_next.key   = bus.key;
                data_next.value = bus.value;
                data_next.seen  = 1'b0;
                data_next.stamp = '0;
            end
            mlru_pkg::CELL_STAMP:
            begin
                data_next.value = bus.value;
                data_next.seen  = 1'b1;
                data_next.stamp = bus.stamp;
            end
            mlru_pkg::CELL_WRVAL:
            begin
                data_next.value = bus.value;
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

>>> hdl/midpoint_lru_cache_top.sv
// Midpoint-insertion LRU key/value cache with up to 16 entries.
// Input channel: in_valid/in_stall carries one request item (req_type 0 get,
// 1 put, lookup_key, write_value, now_ms). Output channel: out_valid/out_stall
// carries one result item per request (hit, read_value, evicted, evicted_key).
// Configuration: cfg_we writes cfg_data into register cfg_index (0 capacity,
// 1 promotion_delay) at the clock edge; write only while the cache is idle.
// Entries live in a row of cells, one per list position; each cell compares
// its key in parallel and can take its left neighbor's contents, so moves to
// the head and inserts at the midpoint shift the whole row in a single update.
// Each request passes a search step (parallel key compare, registered) and an
// update step (list update, result registered into the output register).
// A new request is accepted only in ST_IDLE, so none is taken before the last
// one's update is done; the search and update steps share the cell row.
// If a result is still held by a stalled receiver when the next update is
// ready, the update waits in place until the output register frees up.
// Reset (rst_n low, asynchronous) empties the list, sets capacity to 16 and
// promotion_delay to 0; entry contents are not cleared.
module midpoint_lru_cache_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                req_type,
    input  logic signed [mlru_pkg::KEY_W-1:0]   lookup_key,
    input  logic signed [mlru_pkg::VAL_W-1:0]   write_value,
    input  logic        [mlru_pkg::TIME_W-1:0]  now_ms,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                hit,
    output logic signed [mlru_pkg::VAL_W-1:0]   read_value,
    output logic                                evicted,
    output logic signed [mlru_pkg::KEY_W-1:0]   evicted_key,
    input  logic                                cfg_we,
    input  logic        [mlru_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic        [mlru_pkg::CFG_W-1:0]   cfg_data
);

    localparam int N = mlru_pkg::MAX_ENTRIES;
    localparam int CW = mlru_pkg::CNT_W;
    localparam int LW = mlru_pkg::LIM_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_UPDATE
    } state_t;

    // control state
    state_t                        state_reg, state_next;
    logic                          out_valid_reg, out_valid_next;
    logic [CW-1:0]                 occ_reg, occ_next;
    logic [CW-1:0]                 nc_reg, nc_next;
    logic [mlru_pkg::CAP_W-1:0]    cap_reg, cap_next;
    logic [mlru_pkg::TIME_W-1:0]   delay_reg, delay_next;

    // request and search payload
    logic                          req_put_reg;
    logic [mlru_pkg::KEY_W-1:0]    req_key_reg;
    logic [mlru_pkg::VAL_W-1:0]    req_value_reg;
    logic [mlru_pkg::TIME_W-1:0]   req_now_reg;
    logic [N-1:0]                  first_reg;
    logic [mlru_pkg::IDX_W-1:0]    found_reg;
    logic                          found_hit_reg;

    // result payload
    logic                          hit_reg, hit_next;
    logic [mlru_pkg::VAL_W-1:0]    rv_reg, rv_next;
    logic                          ev_reg, ev_next;
    logic [mlru_pkg::KEY_W-1:0]    evk_reg, evk_next;

    // cell row
    mlru_pkg::cell_data_t          cell_q [N];
    mlru_pkg::cell_data_t          cell_left [N];
    mlru_pkg::cell_op_t            cell_op [N];
    logic [N-1:0]                  cell_match;
    mlru_pkg::cell_bus_t           bus;

    logic                          in_fire;
    logic                          do_update;
    logic [N-1:0]                  masked;
    logic [N-1:0]                  first_onehot;
    logic [mlru_pkg::IDX_W-1:0]    found_idx;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_fire   = in_valid && !in_stall;
    assign do_update = (state_reg == ST_UPDATE) && (!out_valid_reg || !out_stall);

    assign out_valid   = out_valid_reg;
    assign hit         = hit_reg;
    assign read_value  = rv_reg;
    assign evicted     = ev_reg;
    assign evicted_key = evk_reg;

    // row of cells, each fed by its left neighbor (the head cell by zero)
    genvar g;
    generate
        for (g = 0; g < N; g++)
        begin : g_cell
            if (g == 0)
            begin : g_head
                assign cell_left[g] = '0;
            end
            else
            begin : g_body
                assign cell_left[g] = cell_q[g-1];
            end
            mlru_cell u_cell (
                .clk        (clk),
                .op         (cell_op[g]),
                .bus        (bus),
                .left_data  (cell_left[g]),
                .search_key (req_key_reg),
                .data       (cell_q[g]),
                .match      (cell_match[g])
            );
        end
    endgenerate

    // search: occupied matches and the first one
    always_comb
    begin
        masked = '0;
        found_idx = '0;
        for (int i = 0; i < N; i++)
        begin
            masked[i] = cell_match[i] && (CW'(i) < occ_reg);
        end
        first_onehot = masked & (~masked + N'(1));
        for (int i = N - 1; i >= 0; i--)
        begin
            if (masked[i])
            begin
                found_idx = mlru_pkg::IDX_W'(i);
            end
        end
    end

    // update: list moves, counters and result
    logic [mlru_pkg::VAL_W-1:0]  sel_value;
    logic                        sel_seen;
    logic [mlru_pkg::TIME_W-1:0] sel_stamp;
    logic [mlru_pkg::VAL_W-1:0]  value_after;
    logic [mlru_pkg::TIME_W-1:0] elapsed;
    logic                        promote_ok;
    logic                        in_new;
    logic                        head_move;
    logic [CW-1:0]               found_ext;
    logic [LW-1:0]               lim;
    logic                        do_evict;
    logic [CW-1:0]               occ_a;
    logic [CW-1:0]               nc_a;
    logic [CW-1:0]               tail_pos;
    logic [mlru_pkg::KEY_W-1:0]  tail_key;
    mlru_pkg::cell_op_t          op_calc [N];

    always_comb
    begin
        sel_value = '0;
        sel_seen  = 1'b0;
        sel_stamp = '0;
        tail_key  = '0;
        tail_pos  = CW'(occ_reg - CW'(1));
        for (int i = 0; i < N; i++)
        begin
            if (first_reg[i])
            begin
                sel_value = sel_value | cell_q[i].value;
                sel_seen  = sel_seen  | cell_q[i].seen;
                sel_stamp = sel_stamp | cell_q[i].stamp;
            end
            if (CW'(i) == tail_pos)
            begin
                tail_key = cell_q[i].key;
            end
        end

        value_after = req_put_reg ? req_value_reg : sel_value;
        elapsed     = req_now_reg - sel_stamp;
        promote_ok  = elapsed > delay_reg;
        found_ext   = CW'(found_reg);
        in_new      = found_ext < nc_reg;
        head_move   = in_new || (sel_seen && promote_ok);

        // effective capacity
        if (cap_reg == '0)
        begin
            lim = LW'(1);
        end
        else if (LW'(cap_reg) > LW'(N))
        begin
            lim = LW'(N);
        end
        else
        begin
            lim = LW'(cap_reg);
        end
        do_evict = (LW'(occ_reg) >= lim) && (occ_reg != '0);
        occ_a    = occ_reg - CW'(do_evict);
        nc_a     = (nc_reg > occ_a) ? occ_a : nc_reg;

        occ_next   = occ_reg;
        nc_next    = nc_reg;
        hit_next   = 1'b0;
        rv_next    = '0;
        ev_next    = 1'b0;
        evk_next   = '0;
        bus.key    = req_key_reg;
        bus.value  = value_after;
        bus.stamp  = req_now_reg;
        for (int i = 0; i < N; i++)
        begin
            op_calc[i] = mlru_pkg::CELL_HOLD;
        end

        if (found_hit_reg)
        begin
            hit_next = 1'b1;
            rv_next  = value_after;
            if (head_move)
            begin
                if (!in_new)
                begin
                    nc_next = nc_reg + CW'(1);
                end
                for (int i = 0; i < N; i++)
                begin
                    if (i == 0)
                    begin
                        op_calc[i] = mlru_pkg::CELL_LOAD;
                    end
                    else if (CW'(i) <= found_ext)
                    begin
                        op_calc[i] = mlru_pkg::CELL_SHIFT;
                    end
                end
            end
            else
            begin
                for (int i = 0; i < N; i++)
                begin
                    if (first_reg[i])
                    begin
                        op_calc[i] = sel_seen ? mlru_pkg::CELL_WRVAL : mlru_pkg::CELL_STAMP;
                    end
                end
            end
        end
        else if (req_put_reg)
        begin
            // insert at the head of the old region
            bus.value = req_value_reg;
            ev_next   = do_evict;
            evk_next  = do_evict ? tail_key : '0;
            occ_next  = occ_a + CW'(1);
            nc_next   = nc_a;
            for (int i = 0; i < N; i++)
            begin
                if (CW'(i) == nc_a)
                begin
                    op_calc[i] = mlru_pkg::CELL_LOAD;
                end
                else if ((CW'(i) > nc_a) && (CW'(i) <= occ_a))
                begin
                    op_calc[i] = mlru_pkg::CELL_SHIFT;
                end
            end
        end

        for (int i = 0; i < N; i++)
        begin
            cell_op[i] = do_update ? op_calc[i] : mlru_pkg::CELL_HOLD;
        end
    end

    // sequencing, counters and configuration
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cap_next       = cap_reg;
        delay_next     = delay_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                if (do_update)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_we)
        begin
            case (cfg_index)
                mlru_pkg::REG_CAPACITY:
                begin
                    cap_next = cfg_data[mlru_pkg::CAP_W-1:0];
                end
                mlru_pkg::REG_PROMOTION_DELAY:
                begin
                    delay_next = cfg_data[mlru_pkg::TIME_W-1:0];
                end
                default:
                begin
                    cap_next = cap_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            occ_reg       <= '0;
            nc_reg        <= '0;
            cap_reg       <= mlru_pkg::CAPACITY_RESET;
            delay_reg     <= mlru_pkg::DELAY_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            cap_reg       <= cap_next;
            delay_reg     <= delay_next;
            if (do_update)
            begin
                occ_reg <= occ_next;
                nc_reg  <= nc_next;
            end
        end
    end

    // request capture, search result and result payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            req_put_reg   <= req_type;
            req_key_reg   <= lookup_key;
            req_value_reg <= write_value;
            req_now_reg   <= now_ms;
        end
        if (state_reg == ST_SEARCH)
        begin
            first_reg     <= first_onehot;
            found_reg     <= found_idx;
            found_hit_reg <= (masked != '0);
        end
        if (do_update)
        begin
            hit_reg <= hit_next;
            rv_reg  <= rv_next;
            ev_reg  <= ev_next;
            evk_reg <= evk_next;
        end
    end

endmodule

>>> hdl/mlru_checker.sv
module mlru_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_stall,
    input logic                              out_valid,
    input logic                              out_stall,
    input logic                              hit,
    input logic [mlru_pkg::VAL_W-1:0]        read_value,
    input logic                              evicted,
    input logic [mlru_pkg::KEY_W-1:0]        evicted_key
);

    // one request in flight: no accept right after an accept
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("request accepted while another is in flight");

    // a held result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid)
        else $error("result dropped while stalled");

    // a hit never evicts
    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(hit && evicted))
        else $error("hit and eviction in one item");

    // a miss reads zero and no eviction carries a zero key
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((hit || read_value == '0) && (evicted || evicted_key == '0)))
        else $error("miss or non-eviction with nonzero data");

endmodule

bind midpoint_lru_cache_top mlru_checker u_mlru_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .hit         (hit),
    .read_value  (read_value),
    .evicted     (evicted),
    .evicted_key (evicted_key)
);

>>> bench/midpoint_lru_cache_top_tb.sv
`timescale 1ns / 1ps

module midpoint_lru_cache_top_tb;

    localparam logic REQ_GET = 1'b0;
    localparam logic REQ_PUT = 1'b1;
    localparam int   QUIET_LIMIT = 1000;
    localparam int   PHASE_ITEMS = 170;

    typedef struct packed {
        logic                        req_type;
        logic [mlru_pkg::KEY_W-1:0]  key;
        logic [mlru_pkg::VAL_W-1:0]  value;
        logic [mlru_pkg::TIME_W-1:0] now;
    } request_t;

    typedef struct packed {
        logic                       hit;
        logic [mlru_pkg::VAL_W-1:0] read_value;
        logic                       evicted;
        logic [mlru_pkg::KEY_W-1:0] evicted_key;
    } result_t;

    typedef enum {ROW_REQUEST, ROW_WRITE} row_kind_t;

    typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    typedef struct {
        row_kind_t                       kind;
        request_t                        req;
        logic [mlru_pkg::CFG_IDX_W-1:0]  idx;
        logic [mlru_pkg::CFG_W-1:0]      data;
        bit                              typed;
        result_t                         want;
    } script_row_t;

    // dut ports
    logic                                 clk = 1'b0;
    logic                                 rst_n = 1'b0;
    logic                                 in_valid = 1'b0;
    logic                                 in_stall;
    logic                                 req_type = 1'b0;
    logic signed [mlru_pkg::KEY_W-1:0]    lookup_key = '0;
    logic signed [mlru_pkg::VAL_W-1:0]    write_value = '0;
    logic        [mlru_pkg::TIME_W-1:0]   now_ms = '0;
    logic                                 out_valid;
    logic                                 out_stall = 1'b0;
    logic                                 hit;
    logic signed [mlru_pkg::VAL_W-1:0]    read_value;
    logic                                 evicted;
    logic signed [mlru_pkg::KEY_W-1:0]    evicted_key;
    logic                                 cfg_we = 1'b0;
    logic        [mlru_pkg::CFG_IDX_W-1:0] cfg_index = mlru_pkg::REG_CAPACITY;
    logic        [mlru_pkg::CFG_W-1:0]    cfg_data = '0;

    // shadow copy of the entry list and its registers
    mlru_pkg::cell_data_t        shadow [mlru_pkg::MAX_ENTRIES];
    int                          held_entries = 0;
    int                          fresh_entries = 0;
    logic [mlru_pkg::CAP_W-1:0]  cap_reg = mlru_pkg::CAPACITY_RESET;
    logic [mlru_pkg::TIME_W-1:0] delay_reg = mlru_pkg::DELAY_RESET;

    // results still owed by the cache, oldest first
    result_t     owed_results [$];
    script_row_t script [$];

    idle_mode_t idle_mode = IDLE_NONE;
    bit         row_typed = 1'b0;
    result_t    row_want = '0;
    int         mismatches = 0;
    int         quiet_cycles = 0;
    int         requests_seen = 0;
    int         hits_seen = 0;
    int         evictions_seen = 0;
    int         promotions_seen = 0;
    int         settings_used = 0;

    midpoint_lru_cache_top DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .req_type    (req_type),
        .lookup_key  (lookup_key),
        .write_value (write_value),
        .now_ms      (now_ms),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .hit         (hit),
        .read_value  (read_value),
        .evicted     (evicted),
        .evicted_key (evicted_key),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always #5 clk = ~clk;

    // move one entry to the head, shifting the ones above it down
    function automatic void move_to_head(int p);
        mlru_pkg::cell_data_t c;
        c = shadow[p];
        for (int i = p; i > 0; i--)
            shadow[i] = shadow[i-1];
        c.seen  = 1'b0;
        c.stamp = '0;
        shadow[0] = c;
    endfunction

    // lookup, update or insert in the shadow list; returns the result item
    function automatic result_t cache_access(request_t r);
        result_t                     res;
        int                          found;
        int                          lim;
        logic [mlru_pkg::TIME_W-1:0] elapsed;
        res   = '0;
        found = held_entries;
        for (int p = 0; p < held_entries; p++)
        begin
            if (shadow[p].key == r.key)
            begin
                found = p;
                break;
            end
        end
        if (found < held_entries)
        begin
            res.hit = 1'b1;
            if (r.req_type == REQ_PUT)
                shadow[found].value = r.value;
            res.read_value = shadow[found].value;
            elapsed = r.now - shadow[found].stamp;
            if (found < fresh_entries)
            begin
                move_to_head(found);
            end
            else if (!shadow[found].seen)
            begin
                shadow[found].seen  = 1'b1;
                shadow[found].stamp = r.now;
            end
            else if (elapsed > delay_reg)
            begin
                move_to_head(found);
                fresh_entries++;
                promotions_seen++;
            end
        end
        else if (r.req_type == REQ_PUT)
        begin
            lim = int'(cap_reg);
            if (lim == 0)
                lim = 1;
            if (lim > mlru_pkg::MAX_ENTRIES)
                lim = mlru_pkg::MAX_ENTRIES;
            // full, or over a lowered capacity: drop only the tail
            if (held_entries >= lim && held_entries > 0)
            begin
                res.evicted     = 1'b1;
                res.evicted_key = shadow[held_entries-1].key;
                held_entries--;
                if (fresh_entries > held_entries)
                    fresh_entries = held_entries;
            end
            // insert at the head of the old region
            for (int p = held_entries; p > fresh_entries; p--)
                shadow[p] = shadow[p-1];
            shadow[fresh_entries].key   = r.key;
            shadow[fresh_entries].value = r.value;
            shadow[fresh_entries].seen  = 1'b0;
            shadow[fresh_entries].stamp = '0;
            held_entries++;
        end
        return res;
    endfunction

    // directed rows
    function automatic void add_req(logic t, logic [31:0] k, logic [31:0] v, logic [31:0] n);
        script_row_t row;
        row.kind  = ROW_REQUEST;
        row.req   = '{t, k, v, n};
        row.idx   = mlru_pkg::REG_CAPACITY;
        row.data  = '0;
        row.typed = 1'b0;
        row.want  = '0;
        script.push_back(row);
    endfunction

    function automatic void add_checked(logic t, logic [31:0] k, logic [31:0] v,
                                        logic [31:0] n, logic h, logic [31:0] rv);
        add_req(t, k, v, n);
        script[$].typed = 1'b1;
        script[$].want  = '{h, rv, 1'b0, mlru_pkg::KEY_W'(0)};
    endfunction

    function automatic void add_write(logic [mlru_pkg::CFG_IDX_W-1:0] idx,
                                      logic [mlru_pkg::CFG_W-1:0] data);
        script_row_t row;
        row.kind  = ROW_WRITE;
        row.req   = '0;
        row.idx   = idx;
        row.data  = data;
        row.typed = 1'b0;
        row.want  = '0;
        script.push_back(row);
    endfunction

    function automatic int idle_rate(bit sender);
        if (idle_mode == IDLE_BOTH)
            return 26;
        if (sender && idle_mode == IDLE_SENDER)
            return 53;
        if (!sender && idle_mode == IDLE_RECEIVER)
            return 53;
        return 0;
    endfunction

    // present one item and hold it until accepted
    task automatic send_item(request_t r, bit typed, result_t want);
        while ($urandom_range(0, 99) < idle_rate(1'b1))
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        row_typed   = typed;
        row_want    = want;
        in_valid    <= 1'b1;
        req_type    <= r.req_type;
        lookup_key  <= r.key;
        write_value <= r.value;
        now_ms      <= r.now;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    // hold off until every owed result has come back, then let the pipe empty
    task automatic settle();
        in_valid <= 1'b0;
        while (owed_results.size() > 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(logic [mlru_pkg::CFG_IDX_W-1:0] idx,
                             logic [mlru_pkg::CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        if (idx == mlru_pkg::REG_CAPACITY)
            cap_reg = data[mlru_pkg::CAP_W-1:0];
        else if (idx == mlru_pkg::REG_PROMOTION_DELAY)
            delay_reg = data;
        settings_used++;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // random receiver stall
    always @(negedge clk)
        out_stall <= ($urandom_range(0, 99) < idle_rate(1'b0));

    // accept side: predict; result side: compare; plus the watchdog
    always @(posedge clk)
    begin
        request_t r;
        result_t  predicted;
        result_t  observed;
        if (rst_n)
        begin
            quiet_cycles++;
            if (in_valid && !in_stall)
            begin
                r = '{req_type, lookup_key, write_value, now_ms};
                predicted = cache_access(r);
                if (row_typed)
                    predicted = row_want;
                owed_results.push_back(predicted);
                requests_seen++;
                hits_seen += predicted.hit;
                evictions_seen += predicted.evicted;
                quiet_cycles = 0;
            end
            if (out_valid && !out_stall)
            begin
                quiet_cycles = 0;
                observed = '{hit, read_value, evicted, evicted_key};
                if (owed_results.size() == 0)
                begin
                    $error("result with nothing owed: hit %0d value %0h", hit, read_value);
                    mismatches++;
                end
                else
                begin
                    predicted = owed_results.pop_front();
                    if (observed.hit !== predicted.hit)
                    begin
                        $error("hit: expected %0d, got %0d", predicted.hit, observed.hit);
                        mismatches++;
                    end
                    if (observed.read_value !== predicted.read_value)
                    begin
                        $error("read_value: expected %0h, got %0h",
                               predicted.read_value, observed.read_value);
                        mismatches++;
                    end
                    if (observed.evicted !== predicted.evicted)
                    begin
                        $error("evicted: expected %0d, got %0d",
                               predicted.evicted, observed.evicted);
                        mismatches++;
                    end
                    if (observed.evicted_key !== predicted.evicted_key)
                    begin
                        $error("evicted_key: expected %0h, got %0h",
                               predicted.evicted_key, observed.evicted_key);
                        mismatches++;
                    end
                end
            end
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("watchdog: no traffic for %0d cycles", QUIET_LIMIT);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    initial
    begin
        logic [mlru_pkg::CAP_W-1:0]  phase_cap   [9];
        logic [mlru_pkg::TIME_W-1:0] phase_delay [9];
        logic [mlru_pkg::KEY_W-1:0]  key_pool [$];
        logic [mlru_pkg::TIME_W-1:0] clock_ms;
        request_t                    r;
        int                          eff_cap;
        int                          step_max;

        phase_cap   = '{5'd16, 5'd4, 5'd1, 5'd8, 5'd16, 5'd2, 5'd0, 5'd31, 5'd11};
        phase_delay = '{32'd0, 32'd10, 32'd0, 32'hFFFF_FFFF, 32'd3, 32'd1, 32'd5,
                        32'd20, 32'h0001_0000};

        // extremes, wrap of the clock, zero stamp, put on an existing key
        add_checked(REQ_GET, 32'h0000_0000, 32'h0,         32'h0,         1'b0, 32'h0);
        add_checked(REQ_PUT, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0,         1'b0, 32'h0);
        add_checked(REQ_PUT, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0, 32'h0);
        add_checked(REQ_GET, 32'h7FFF_FFFF, 32'h0,         32'hFFFF_FFFF, 1'b1, 32'h8000_0000);
        add_checked(REQ_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0,         1'b1, 32'h8000_0000);
        add_checked(REQ_GET, 32'h7FFF_FFFF, 32'h0,         32'h0,         1'b1, 32'h8000_0000);
        add_checked(REQ_PUT, 32'h8000_0000, 32'h1234_5678, 32'h5,         1'b1, 32'h1234_5678);
        add_checked(REQ_GET, 32'hFFFF_FFFF, 32'h0,         32'h5,         1'b0, 32'h0);
        add_checked(REQ_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0,         1'b0, 32'h0);
        add_req(REQ_GET, 32'hFFFF_FFFF, 32'h0, 32'h0);
        add_req(REQ_GET, 32'hFFFF_FFFF, 32'h0, 32'h0);
        add_req(REQ_GET, 32'hFFFF_FFFF, 32'h0, 32'h1);
        // last old entry promoted: the old region is empty
        add_req(REQ_GET, 32'h8000_0000, 32'h0, 32'h6);
        add_write(mlru_pkg::REG_CAPACITY, 32'd3);
        add_req(REQ_PUT, 32'h0000_0001, 32'h1, 32'h7);
        add_checked(REQ_GET, 32'h7FFF_FFFF, 32'h0, 32'h7, 1'b0, 32'h0);
        // capacity lowered while full, then zero, then above the maximum
        add_write(mlru_pkg::REG_CAPACITY, 32'd2);
        add_req(REQ_PUT, 32'h0000_0002, 32'h2, 32'h8);
        add_write(mlru_pkg::REG_CAPACITY, 32'd0);
        add_req(REQ_PUT, 32'h0000_0003, 32'h3, 32'h9);
        add_write(mlru_pkg::REG_CAPACITY, 32'd31);
        add_req(REQ_PUT, 32'h0000_0004, 32'h4, 32'd10);
        add_write(mlru_pkg::REG_PROMOTION_DELAY, 32'hFFFF_FFFF);
        add_req(REQ_GET, 32'h0000_0004, 32'h0, 32'd100);
        add_req(REQ_GET, 32'h0000_0004, 32'h0, 32'd50);
        add_req(REQ_PUT, 32'h0000_0004, 32'h55AA, 32'd200);

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed part
        foreach (script[i])
        begin
            if (script[i].kind == ROW_WRITE)
            begin
                settle();
                write_reg(script[i].idx, script[i].data);
            end
            else
            begin
                send_item(script[i].req, script[i].typed, script[i].want);
            end
        end

        // random phases, each with its own settings and idling
        foreach (phase_cap[ph])
        begin
            settle();
            idle_mode = idle_mode_t'(ph % 4);
            write_reg(mlru_pkg::REG_CAPACITY, mlru_pkg::CFG_W'(phase_cap[ph]));
            write_reg(mlru_pkg::REG_PROMOTION_DELAY, phase_delay[ph]);
            eff_cap = (phase_cap[ph] == 0) ? 1 :
                      (phase_cap[ph] > mlru_pkg::MAX_ENTRIES) ? mlru_pkg::MAX_ENTRIES :
                      int'(phase_cap[ph]);
            step_max = (phase_delay[ph] <= 64) ? 2 * int'(phase_delay[ph]) + 2 : 16;
            key_pool.delete();
            repeat (eff_cap + $urandom_range(1, 4))
                key_pool.push_back($urandom());
            clock_ms = $urandom();
            repeat (PHASE_ITEMS)
            begin
                // now and then let everything drain before the next item
                if ($urandom_range(0, 79) == 0)
                    settle();
                if ($urandom_range(0, 39) == 0)
                    clock_ms = $urandom();
                else
                    clock_ms = clock_ms + $urandom_range(0, step_max);
                r.req_type = ($urandom_range(0, 99) < 35) ? REQ_PUT : REQ_GET;
                if ($urandom_range(0, 9) == 0)
                    r.key = $urandom();
                else
                    r.key = key_pool[$urandom_range(0, key_pool.size() - 1)];
                r.value = $urandom();
                r.now   = clock_ms;
                send_item(r, 1'b0, '0);
            end
        end

        idle_mode = IDLE_NONE;
        settle();
        $display("covered %0d requests: %0d hits, %0d evictions, %0d promotions",
                 requests_seen, hits_seen, evictions_seen, promotions_seen);
        $display("register writes: %0d, with capacities 0 to 31 and delays 0 to max",
                 settings_used);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
